// File: hdl/maxg_pkg.sv
package maxg_pkg;

   // widths fixed by the field definitions
   localparam int VALUE_W    = 16;
   localparam int CHAN_W     = 8;
   localparam int SW_W       = 4;
   localparam int GS_RAW_W   = 5;
   localparam int CC_RAW_W   = 9;
   localparam int PC_W       = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_SIZE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POSITION_COUNT = 2'd2;

   // result kinds
   localparam logic KIND_FWD = 1'b0;
   localparam logic KIND_BWD = 1'b1;

   typedef struct packed {
      logic                      kind;
      logic signed [VALUE_W-1:0] value;
      logic [CHAN_W-1:0]         channel;
      logic [CHAN_W-1:0]         winner;
      logic                      last;
   } rsp_type;

endpackage

// File: hdl/maxout_group_max_with_grad_route.sv
// maxout pooling over channel groups, forward maximum and backward gradient routing
//
// req channel: one item per transfer, req_cmd 0 carries an activation, 1 an output
//   gradient; activations and gradients arrive in channel order per position
// rsp channel: forward group maxima (kind 0) and backward input gradients (kind 1),
//   every run of results for one item ends with rsp_last
// csr channel: csr_ready is always high; a write to any of the three registers
//   restarts all counters, the switch memory keeps its contents
// forward: items are taken back to back while req_stall is low; a forward result is
//   pushed into the output queue with the transfer that closes its group
// a backward item reads its switch entry from the memory (a registered read) and then
//   gives its n results, one result per cycle from the gradient sequencer while the
//   output queue has room; the next item is taken once the run is out
// reset: counters cleared, registers back to group 2, channels 2, positions 1;
//   the switch memory is not cleared and holds nothing useful until written
// rsp stall: a two-entry output queue absorbs one result while another waits, then
//   req_stall rises and the sequencer holds its place
module maxout_group_max_with_grad_route
   import maxg_pkg::*;
#(
   parameter int MAX_GROUP      = 16,
   parameter int MAX_CHANNELS   = 256,
   parameter int SWITCH_ENTRIES = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_cmd,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_kind,
   output logic signed [VALUE_W-1:0] rsp_result_value,
   output logic [CHAN_W-1:0]         rsp_channel,
   output logic [CHAN_W-1:0]         rsp_winner_channel,
   output logic                      rsp_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   localparam int GS_W  = $clog2(MAX_GROUP + 1);
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
   localparam int AW    = $clog2(SWITCH_ENTRIES);

   // raw register values
   logic [GS_RAW_W-1:0] gs_raw_ff;
   logic [CC_RAW_W-1:0] cc_raw_ff;
   logic [PC_W-1:0]     pc_raw_ff;

   // clamped values seen by the datapath
   logic [GS_W-1:0]     gs_eff;
   logic [CNT_W-1:0]    cc_eff;
   logic [PC_W-1:0]     pc_eff;

   logic                cfg_clear;
   logic                accept, fwd_accept, bwd_accept;
   logic                fwd_push, bwd_push, bwd_busy;
   rsp_type             fwd_rsp, bwd_rsp, q_din, q_dout;
   logic                q_full, q_pop;

   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [SW_W-1:0]     wr_data, rd_data;

   // csr writes, any known index restarts the counters
   always_ff @(posedge clock) begin
      if (reset) begin
         gs_raw_ff <= GS_RAW_W'(2);
         cc_raw_ff <= CC_RAW_W'(2);
         pc_raw_ff <= PC_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GROUP_SIZE:     gs_raw_ff <= csr_data[GS_RAW_W-1:0];
            CSR_CHANNEL_COUNT:  cc_raw_ff <= csr_data[CC_RAW_W-1:0];
            CSR_POSITION_COUNT: pc_raw_ff <= csr_data[PC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg_clear = csr_valid && csr_ready &&
                  ((csr_index == CSR_GROUP_SIZE) || (csr_index == CSR_CHANNEL_COUNT) ||
                   (csr_index == CSR_POSITION_COUNT));

      if (gs_raw_ff == '0) gs_eff = GS_W'(1);
      else if (32'(gs_raw_ff) > MAX_GROUP) gs_eff = GS_W'(MAX_GROUP);
      else gs_eff = GS_W'(gs_raw_ff);

      if (cc_raw_ff == '0) cc_eff = CNT_W'(1);
      else if (32'(cc_raw_ff) > MAX_CHANNELS) cc_eff = CNT_W'(MAX_CHANNELS);
      else cc_eff = CNT_W'(cc_raw_ff);

      pc_eff = (pc_raw_ff == '0) ? PC_W'(1) : pc_raw_ff;
   end

   assign csr_ready = 1'b1;

   // hold requests while a gradient run is out or the output queue is full
   assign req_stall  = bwd_busy || q_full;
   assign accept     = req_valid && !req_stall;
   assign fwd_accept = accept && !req_cmd;
   assign bwd_accept = accept && req_cmd;

   maxg_fwd #(
      .MAX_GROUP      (MAX_GROUP),
      .MAX_CHANNELS   (MAX_CHANNELS),
      .SWITCH_ENTRIES (SWITCH_ENTRIES)
   ) u_fwd (
      .clock   (clock),
      .reset   (reset),
      .clear   (cfg_clear),
      .accept  (fwd_accept),
      .value   (req_value),
      .gs      (gs_eff),
      .cc      (cc_eff),
      .pc      (pc_eff),
      .push    (fwd_push),
      .rsp     (fwd_rsp),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   maxg_bwd #(
      .MAX_GROUP      (MAX_GROUP),
      .MAX_CHANNELS   (MAX_CHANNELS),
      .SWITCH_ENTRIES (SWITCH_ENTRIES)
   ) u_bwd (
      .clock   (clock),
      .reset   (reset),
      .clear   (cfg_clear),
      .accept  (bwd_accept),
      .value   (req_value),
      .gs      (gs_eff),
      .cc      (cc_eff),
      .pc      (pc_eff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .room    (!q_full),
      .push    (bwd_push),
      .rsp     (bwd_rsp),
      .busy    (bwd_busy)
   );

   // switch offsets, written when a forward group closes and read by backward items; a
   // write and a read never fall in the same cycle, since each comes from its own transfer
   maxg_switch_ram #(
      .SWITCH_ENTRIES (SWITCH_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // forward pushes and gradient runs never overlap
   assign q_din = fwd_push ? fwd_rsp : bwd_rsp;
   assign q_pop = rsp_valid && !rsp_stall;

   maxg_outq u_outq (
      .clock (clock),
      .reset (reset),
      .push  (fwd_push || bwd_push),
      .din   (q_din),
      .pop   (q_pop),
      .valid (rsp_valid),
      .full  (q_full),
      .dout  (q_dout)
   );

   assign rsp_kind           = q_dout.kind;
   assign rsp_result_value   = q_dout.value;
   assign rsp_channel        = q_dout.channel;
   assign rsp_winner_channel = q_dout.winner;
   assign rsp_last           = q_dout.last;

endmodule

// File: hdl/maxg_switch_ram.sv
module maxg_switch_ram
   import maxg_pkg::*;
#(
   parameter int SWITCH_ENTRIES = 4096,
   localparam int AW = $clog2(SWITCH_ENTRIES)
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  logic [SW_W-1:0] wr_data,
   input  logic            rd_en,
   input  logic [AW-1:0]   rd_addr,
   output logic [SW_W-1:0] rd_data
);

   logic [SW_W-1:0] mem [SWITCH_ENTRIES];
   logic [SW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/maxg_fwd.sv
module maxg_fwd
   import maxg_pkg::*;
#(
   parameter int MAX_GROUP      = 16,
   parameter int MAX_CHANNELS   = 256,
   parameter int SWITCH_ENTRIES = 4096,
   localparam int GS_W  = $clog2(MAX_GROUP + 1),
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1),
   localparam int SUM_W = $clog2(MAX_CHANNELS + 2 * MAX_GROUP + 1),
   localparam int AW    = $clog2(SWITCH_ENTRIES)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  logic                      accept,
   input  logic signed [VALUE_W-1:0] value,
   input  logic [GS_W-1:0]           gs,
   input  logic [CNT_W-1:0]          cc,
   input  logic [PC_W-1:0]           pc,
   output logic                      push,
   output rsp_type                   rsp,
   output logic                      wr_en,
   output logic [AW-1:0]             wr_addr,
   output logic [SW_W-1:0]           wr_data
);

   logic [CNT_W-1:0]          ch_ff, base_ff, grp_ff;
   logic [GS_W-1:0]           mc_ff, roff_ff;
   logic signed [VALUE_W-1:0] rmax_ff;
   logic [PC_W-1:0]           pos_ff;
   logic [AW-1:0]             addr_ff;

   logic [SUM_W-1:0]          grp_end, winner_sum;
   logic                      in_group, take, done, ch_wrap, pos_wrap;
   logic signed [VALUE_W-1:0] max_in;
   logic [GS_W-1:0]           off_in, mc_in;
   logic [SUM_W+CHAN_W-1:0]   winner_ext;
   logic [CNT_W+CHAN_W-1:0]   grp_ext;
   logic [GS_W+SW_W-1:0]      off_ext;
   logic [AW-1:0]             addr_next;

   always_comb begin
      grp_end    = SUM_W'(base_ff) + SUM_W'(gs);
      in_group   = grp_end <= SUM_W'(cc);
      take       = (mc_ff == '0) || (value > rmax_ff);
      max_in     = take ? value : rmax_ff;
      off_in     = take ? mc_ff : roff_ff;
      mc_in      = mc_ff + GS_W'(1);
      done       = in_group && (mc_in >= gs);
      ch_wrap    = (SUM_W'(ch_ff) + SUM_W'(1)) >= SUM_W'(cc);
      pos_wrap   = ({1'b0, pos_ff} + (PC_W + 1)'(1)) >= {1'b0, pc};
      winner_sum = SUM_W'(base_ff) + SUM_W'(off_in);
      winner_ext = {{CHAN_W{1'b0}}, winner_sum};
      grp_ext    = {{CHAN_W{1'b0}}, grp_ff};
      off_ext    = {{SW_W{1'b0}}, off_in};
      addr_next  = (addr_ff == AW'(SWITCH_ENTRIES - 1)) ? '0 : addr_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         ch_ff   <= '0;
         base_ff <= '0;
         grp_ff  <= '0;
         mc_ff   <= '0;
         roff_ff <= '0;
         rmax_ff <= '0;
         pos_ff  <= '0;
         addr_ff <= '0;
      end else if (accept) begin
         if (in_group) begin
            rmax_ff <= max_in;
            if (done) begin
               mc_ff   <= '0;
               roff_ff <= '0;
               base_ff <= CNT_W'(grp_end);
               grp_ff  <= grp_ff + CNT_W'(1);
               addr_ff <= addr_next;
            end else begin
               mc_ff   <= mc_in;
               roff_ff <= off_in;
            end
         end
         if (ch_wrap) begin
            // end of position: restart group tracking
            ch_ff   <= '0;
            base_ff <= '0;
            grp_ff  <= '0;
            mc_ff   <= '0;
            roff_ff <= '0;
            if (pos_wrap) begin
               pos_ff  <= '0;
               addr_ff <= '0;
            end else begin
               pos_ff <= pos_ff + PC_W'(1);
            end
         end else begin
            ch_ff <= ch_ff + CNT_W'(1);
         end
      end
   end

   assign push        = accept && done;
   assign rsp.kind    = KIND_FWD;
   assign rsp.value   = max_in;
   assign rsp.channel = grp_ext[CHAN_W-1:0];
   assign rsp.winner  = winner_ext[CHAN_W-1:0];
   assign rsp.last    = 1'b1;
   assign wr_en       = accept && done;
   assign wr_addr     = addr_ff;
   assign wr_data     = off_ext[SW_W-1:0];

endmodule

// File: hdl/maxg_bwd.sv
module maxg_bwd
   import maxg_pkg::*;
#(
   parameter int MAX_GROUP      = 16,
   parameter int MAX_CHANNELS   = 256,
   parameter int SWITCH_ENTRIES = 4096,
   localparam int GS_W  = $clog2(MAX_GROUP + 1),
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1),
   localparam int SUM_W = $clog2(MAX_CHANNELS + 2 * MAX_GROUP + 1),
   localparam int AW    = $clog2(SWITCH_ENTRIES)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  logic                      accept,
   input  logic signed [VALUE_W-1:0] value,
   input  logic [GS_W-1:0]           gs,
   input  logic [CNT_W-1:0]          cc,
   input  logic [PC_W-1:0]           pc,
   output logic                      rd_en,
   output logic [AW-1:0]             rd_addr,
   input  logic [SW_W-1:0]           rd_data,
   input  logic                      room,
   output logic                      push,
   output rsp_type                   rsp,
   output logic                      busy
);

   logic [CNT_W-1:0]          bbase_ff;
   logic [PC_W-1:0]           bpos_ff;
   logic [AW-1:0]             baddr_ff;
   logic                      em_active_ff, em_route_ff;
   logic [CNT_W-1:0]          em_ch_ff, em_end_ff, em_base_ff;
   logic signed [VALUE_W-1:0] em_grad_ff;

   logic                      no_groups, final_group, pos_wrap, hit, em_last, emit;
   logic [SUM_W-1:0]          end_one, end_two, off;
   logic [CNT_W+CHAN_W-1:0]   ch_ext;
   logic [AW-1:0]             addr_next;

   always_comb begin
      no_groups   = SUM_W'(gs) > SUM_W'(cc);
      end_one     = SUM_W'(bbase_ff) + SUM_W'(gs);
      end_two     = end_one + SUM_W'(gs);
      final_group = end_two > SUM_W'(cc);
      pos_wrap    = ({1'b0, bpos_ff} + (PC_W + 1)'(1)) >= {1'b0, pc};
      addr_next   = (baddr_ff == AW'(SWITCH_ENTRIES - 1)) ? '0 : baddr_ff + AW'(1);
      // offset within the group; leftover channels sit at or past gs
      off         = SUM_W'(em_ch_ff) - SUM_W'(em_base_ff);
      hit         = em_route_ff && (off < SUM_W'(gs)) && (off == SUM_W'(rd_data));
      em_last     = (SUM_W'(em_ch_ff) + SUM_W'(1)) == SUM_W'(em_end_ff);
      emit        = em_active_ff && room;
      ch_ext      = {{CHAN_W{1'b0}}, em_ch_ff};
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         bbase_ff     <= '0;
         bpos_ff      <= '0;
         baddr_ff     <= '0;
         em_active_ff <= 1'b0;
         em_route_ff  <= 1'b0;
         em_ch_ff     <= '0;
         em_end_ff    <= '0;
         em_base_ff   <= '0;
      end else if (accept) begin
         em_active_ff <= 1'b1;
         em_grad_ff   <= value;
         if (no_groups) begin
            em_ch_ff    <= '0;
            em_base_ff  <= '0;
            em_end_ff   <= cc;
            em_route_ff <= 1'b0;
         end else begin
            em_ch_ff    <= bbase_ff;
            em_base_ff  <= bbase_ff;
            em_end_ff   <= final_group ? cc : CNT_W'(end_one);
            em_route_ff <= 1'b1;
            baddr_ff    <= addr_next;
            bbase_ff    <= final_group ? '0 : CNT_W'(end_one);
         end
         if (no_groups || final_group) begin
            if (pos_wrap) begin
               bpos_ff  <= '0;
               baddr_ff <= '0;
            end else begin
               bpos_ff <= bpos_ff + PC_W'(1);
            end
         end
      end else if (emit) begin
         em_ch_ff <= em_ch_ff + CNT_W'(1);
         if (em_last) begin
            em_active_ff <= 1'b0;
         end
      end
   end

   assign rd_en       = accept && !no_groups;
   assign rd_addr     = baddr_ff;
   assign push        = emit;
   assign rsp.kind    = KIND_BWD;
   assign rsp.value   = hit ? em_grad_ff : '0;
   assign rsp.channel = ch_ext[CHAN_W-1:0];
   assign rsp.winner  = '0;
   assign rsp.last    = em_last;
   assign busy        = em_active_ff;

endmodule

// File: hdl/maxg_outq.sv
module maxg_outq
   import maxg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type din,
   input  logic    pop,
   output logic    valid,
   output logic    full,
   output rsp_type dout
);

   rsp_type    slot0_ff, slot1_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         unique case ({push, pop})
            2'b10: begin
               count_ff <= count_ff + 2'd1;
               if (count_ff == 2'd0) slot0_ff <= din;
               else slot1_ff <= din;
            end
            2'b01: begin
               count_ff <= count_ff - 2'd1;
               slot0_ff <= slot1_ff;
            end
            2'b11: begin
               if (count_ff == 2'd1) begin
                  slot0_ff <= din;
               end else begin
                  slot0_ff <= slot1_ff;
                  slot1_ff <= din;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign valid = count_ff != 2'd0;
   assign full  = count_ff == 2'd2;
   assign dout  = slot0_ff;

endmodule

// File: hdl/maxg_checker.sv
module maxg_checker
   import maxg_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_kind,
   input logic [CHAN_W-1:0] rsp_winner_channel,
   input logic              rsp_last
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a group maximum is always a single-result run
   a_fwd_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_FWD) |-> rsp_last)
      else $error("forward result without last");

   a_bwd_winner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_BWD) |-> (rsp_winner_channel == '0))
      else $error("backward result with winner channel");

endmodule

bind maxout_group_max_with_grad_route maxg_checker u_maxg_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_kind           (rsp_kind),
   .rsp_winner_channel (rsp_winner_channel),
   .rsp_last           (rsp_last)
);
